[hw/rtl/med_pkg.sv]
// med_pkg: shared types, constants and helpers for the escape-distance block.
// Depends on nothing; used by med_datapath, med_ctrl and the top level.
package med_pkg;

	localparam int unsigned ITER_BITS_DEF  = 16;
	localparam int unsigned COORD_BITS_DEF = 12;
	localparam int unsigned LIMIT_BITS     = 16;
	localparam int unsigned CFG_IDX_BITS   = 3;

	localparam logic [63:0] ONE_D     = 64'h0000_0001_0000_0000;
	localparam logic [62:0] ERS_RESET = 63'h0400_0000_0000_0000;
	localparam logic [15:0] LIMIT_RESET = 16'd1000;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_X_START = 3'd0,
		REG_Y_START = 3'd1,
		REG_X_STEP  = 3'd2,
		REG_Y_STEP  = 3'd3,
		REG_MAX_IT  = 3'd4,
		REG_ERS     = 3'd5,
		REG_CALC    = 3'd6
	} reg_idx_t;

	// which product the shared multiplier forms
	typedef enum logic [3:0] {
		OP_CR, OP_CI, OP_SR, OP_SI, OP_ZZ, OP_TA, OP_TB, OP_UA, OP_UB
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_CR, ST_CI, ST_INIT, ST_LOOP, ST_SR, ST_SI, ST_MAG, ST_CHK,
		ST_ZZ, ST_TA, ST_TB, ST_UA, ST_UB, ST_UPD, ST_DONE_ESC, ST_DONE_FREE
	} state_t;

	typedef struct packed {
		logic go;
		op_t  op;
		logic load;
		logic init;
		logic mag;
		logic upd;
		logic out;
		logic esc;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic escaped;
		logic limit;
		logic calc;
	} status_t;

	// clamp a 128-bit two's complement value to the signed 64-bit range
	function automatic logic [63:0] sat64(input logic [127:0] v);
		logic [63:0] r;
		if (v[127:64] == {64{v[63]}}) begin
			r = v[63:0];
		end else if (v[127]) begin
			r = 64'h8000_0000_0000_0000;
		end else begin
			r = 64'h7FFF_FFFF_FFFF_FFFF;
		end
		return r;
	endfunction

endpackage

[hw/rtl/med_mul.sv]
// med_mul: multi-cycle signed 64x64 -> 128 multiplier built on one 32x32 unit.
// Depends on nothing; it uses no med_pkg items.
module med_mul (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         go,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic         done,
	output logic [127:0] p
);
	logic [2:0]   ph_q;
	logic [63:0]  ua_q, ub_q, pp_q;
	logic         neg_q, done_q;
	logic [1:0]   sel_q;
	logic [127:0] acc_q, p_q, addend;
	logic [1:0]   idx;
	logic [31:0]  ah, bh;

	always_comb begin
		idx = 2'(ph_q - 3'd1);
		ah = idx[1] ? ua_q[63:32] : ua_q[31:0];
		bh = idx[0] ? ub_q[63:32] : ub_q[31:0];
		case (sel_q)
			2'd0:    addend = {64'b0, pp_q};
			2'd3:    addend = {pp_q, 64'b0};
			default: addend = {32'b0, pp_q, 32'b0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= 3'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (ph_q)
				3'd0: begin
					if (go) begin
						ph_q <= 3'd1;
					end
				end
				3'd6: begin
					ph_q <= 3'd0;
					done_q <= 1'b1;
				end
				default: ph_q <= ph_q + 3'd1;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ph_q == 3'd0 && go) begin
			ua_q <= a[63] ? 64'(-a) : a;
			ub_q <= b[63] ? 64'(-b) : b;
			neg_q <= a[63] ^ b[63];
			acc_q <= '0;
		end
		if (ph_q >= 3'd1 && ph_q <= 3'd4) begin
			pp_q <= {32'b0, ah} * {32'b0, bh};
			sel_q <= idx;
		end
		if (ph_q >= 3'd2 && ph_q <= 3'd5) begin
			acc_q <= acc_q + addend;
		end
		if (ph_q == 3'd6) begin
			p_q <= neg_q ? 128'(-acc_q) : acc_q;
		end
	end

	assign done = done_q;
	assign p = p_q;
endmodule

[hw/rtl/med_datapath.sv]
// med_datapath: config registers, z/d/c state, shared multiplier and result registers.
// Depends on med_pkg and med_mul.
module med_datapath #(
	parameter int unsigned ITER_BITS = med_pkg::ITER_BITS_DEF,
	parameter int unsigned PIXEL_COORD_BITS = med_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  med_pkg::cmd_t                     cmd,
	output med_pkg::status_t                  stat,
	input  logic                              cfg_valid,
	input  logic [med_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [63:0]                       cfg_data,
	input  logic [PIXEL_COORD_BITS-1:0]       px,
	input  logic [PIXEL_COORD_BITS-1:0]       py,
	output logic                              done,
	output logic [ITER_BITS-1:0]              iteration_count,
	output logic signed [63:0]                last_z_re,
	output logic signed [63:0]                last_z_im,
	output logic signed [63:0]                dist_re,
	output logic signed [63:0]                dist_im
);
	logic [63:0] x_start_q, y_start_q, x_step_q, y_step_q;
	logic [15:0] max_it_q;
	logic [62:0] ers_q;
	logic        calc_q;

	logic [PIXEL_COORD_BITS-1:0] px_q, py_q;
	logic [63:0]  cr_q, ci_q, zr_q, zi_q, dr_q, di_q;
	logic [127:0] sr_q, si_q, zz_q, t_q, u_q, diff_q, mag_q;
	logic [ITER_BITS-1:0] count_q;
	logic [med_pkg::LIMIT_BITS-1:0] k_q;
	med_pkg::op_t op_q;
	logic [63:0]  ma, mb;
	logic         mdone;
	logic [127:0] mp;
	logic         done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_start_q <= '0;
			y_start_q <= '0;
			x_step_q <= '0;
			y_step_q <= '0;
			max_it_q <= med_pkg::LIMIT_RESET;
			ers_q <= med_pkg::ERS_RESET;
			calc_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				med_pkg::REG_X_START: x_start_q <= cfg_data;
				med_pkg::REG_Y_START: y_start_q <= cfg_data;
				med_pkg::REG_X_STEP:  x_step_q <= cfg_data;
				med_pkg::REG_Y_STEP:  y_step_q <= cfg_data;
				med_pkg::REG_MAX_IT:  max_it_q <= cfg_data[15:0];
				med_pkg::REG_ERS:     ers_q <= cfg_data[62:0];
				med_pkg::REG_CALC:    calc_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cmd.op)
			med_pkg::OP_CR: begin ma = 64'(px_q); mb = x_step_q; end
			med_pkg::OP_CI: begin ma = 64'(py_q); mb = y_step_q; end
			med_pkg::OP_SR: begin ma = zr_q; mb = zr_q; end
			med_pkg::OP_SI: begin ma = zi_q; mb = zi_q; end
			med_pkg::OP_ZZ: begin ma = zr_q; mb = zi_q; end
			med_pkg::OP_TA: begin ma = zr_q; mb = dr_q; end
			med_pkg::OP_TB: begin ma = zi_q; mb = di_q; end
			med_pkg::OP_UA: begin ma = zr_q; mb = di_q; end
			med_pkg::OP_UB: begin ma = zi_q; mb = dr_q; end
			default:        begin ma = zr_q; mb = zr_q; end
		endcase
	end

	med_mul u_mul (
		.clk(clk), .arst_n(arst_n), .go(cmd.go), .a(ma), .b(mb),
		.done(mdone), .p(mp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.out;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.go) begin
			op_q <= cmd.op;
		end
		if (cmd.load) begin
			px_q <= px;
			py_q <= py;
		end
		if (mdone) begin
			case (op_q)
				med_pkg::OP_CR: cr_q <= med_pkg::sat64({{64{x_start_q[63]}}, x_start_q} + mp);
				med_pkg::OP_CI: ci_q <= med_pkg::sat64({{64{y_start_q[63]}}, y_start_q} + mp);
				med_pkg::OP_SR: sr_q <= mp;
				med_pkg::OP_SI: si_q <= mp;
				med_pkg::OP_ZZ: zz_q <= mp;
				med_pkg::OP_TA: t_q <= mp;
				med_pkg::OP_TB: t_q <= t_q - mp;
				med_pkg::OP_UA: u_q <= mp;
				med_pkg::OP_UB: u_q <= u_q + mp;
				default: ;
			endcase
		end
		if (cmd.init) begin
			zr_q <= cr_q;
			zi_q <= ci_q;
			dr_q <= med_pkg::ONE_D;
			di_q <= '0;
			count_q <= '0;
			k_q <= '0;
		end
		if (cmd.mag) begin
			mag_q <= 128'($signed(sr_q + si_q) >>> 56);
			diff_q <= sr_q - si_q;
		end
		if (cmd.upd) begin
			count_q <= count_q + 1'b1;
			k_q <= k_q + 1'b1;
			zr_q <= med_pkg::sat64(128'($signed(diff_q) >>> 56) + {{64{cr_q[63]}}, cr_q});
			zi_q <= med_pkg::sat64(128'($signed(zz_q) >>> 55) + {{64{ci_q[63]}}, ci_q});
			if (calc_q) begin
				dr_q <= med_pkg::sat64(128'($signed(t_q) >>> 55) + {64'b0, med_pkg::ONE_D});
				di_q <= med_pkg::sat64(128'($signed(u_q) >>> 55));
			end
		end
		if (cmd.out) begin
			iteration_count <= count_q;
			if (cmd.esc) begin
				last_z_re <= zr_q;
				last_z_im <= zi_q;
				dist_re <= calc_q ? dr_q : med_pkg::ONE_D;
				dist_im <= calc_q ? di_q : 64'd0;
			end else begin
				last_z_re <= '0;
				last_z_im <= '0;
				dist_re <= med_pkg::ONE_D;
				dist_im <= '0;
			end
		end
	end

	always_comb begin
		stat.mul_done = mdone;
		stat.escaped = !(mag_q[127:64] == 64'd0 && mag_q[63:0] < {1'b0, ers_q});
		stat.limit = (k_q >= max_it_q);
		stat.calc = calc_q;
	end

	assign done = done_q;
endmodule

[hw/rtl/med_ctrl.sv]
// med_ctrl: sequencer for one pixel; issues datapath commands, reads status.
// Depends on med_pkg.
module med_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output med_pkg::cmd_t    cmd,
	input  med_pkg::status_t stat
);
	med_pkg::state_t state_q, state_d;
	logic issued_q, issued_d;
	logic is_mul;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= med_pkg::ST_IDLE;
			issued_q <= 1'b0;
		end else begin
			state_q <= state_d;
			issued_q <= issued_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.op = med_pkg::OP_SR;
		is_mul = 1'b0;
		unique case (state_q)
			med_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = med_pkg::ST_CR;
				end
			end
			med_pkg::ST_CR:  begin is_mul = 1'b1; cmd.op = med_pkg::OP_CR; end
			med_pkg::ST_CI:  begin is_mul = 1'b1; cmd.op = med_pkg::OP_CI; end
			med_pkg::ST_INIT: begin
				cmd.init = 1'b1;
				state_d = med_pkg::ST_LOOP;
			end
			med_pkg::ST_LOOP: begin
				state_d = stat.limit ? med_pkg::ST_DONE_FREE : med_pkg::ST_SR;
			end
			med_pkg::ST_SR:  begin is_mul = 1'b1; cmd.op = med_pkg::OP_SR; end
			med_pkg::ST_SI:  begin is_mul = 1'b1; cmd.op = med_pkg::OP_SI; end
			med_pkg::ST_MAG: begin
				cmd.mag = 1'b1;
				state_d = med_pkg::ST_CHK;
			end
			med_pkg::ST_CHK: begin
				state_d = stat.escaped ? med_pkg::ST_DONE_ESC : med_pkg::ST_ZZ;
			end
			med_pkg::ST_ZZ:  begin is_mul = 1'b1; cmd.op = med_pkg::OP_ZZ; end
			med_pkg::ST_TA:  begin is_mul = 1'b1; cmd.op = med_pkg::OP_TA; end
			med_pkg::ST_TB:  begin is_mul = 1'b1; cmd.op = med_pkg::OP_TB; end
			med_pkg::ST_UA:  begin is_mul = 1'b1; cmd.op = med_pkg::OP_UA; end
			med_pkg::ST_UB:  begin is_mul = 1'b1; cmd.op = med_pkg::OP_UB; end
			med_pkg::ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = med_pkg::ST_LOOP;
			end
			med_pkg::ST_DONE_ESC: begin
				cmd.out = 1'b1;
				cmd.esc = 1'b1;
				state_d = med_pkg::ST_IDLE;
			end
			med_pkg::ST_DONE_FREE: begin
				cmd.out = 1'b1;
				state_d = med_pkg::ST_IDLE;
			end
			default: state_d = med_pkg::ST_IDLE;
		endcase

		issued_d = issued_q;
		if (is_mul) begin
			cmd.go = !issued_q;
			issued_d = 1'b1;
			if (stat.mul_done) begin
				issued_d = 1'b0;
				unique case (state_q)
					med_pkg::ST_CR: state_d = med_pkg::ST_CI;
					med_pkg::ST_CI: state_d = med_pkg::ST_INIT;
					med_pkg::ST_SR: state_d = med_pkg::ST_SI;
					med_pkg::ST_SI: state_d = med_pkg::ST_MAG;
					med_pkg::ST_ZZ: state_d = stat.calc ? med_pkg::ST_TA : med_pkg::ST_UPD;
					med_pkg::ST_TA: state_d = med_pkg::ST_TB;
					med_pkg::ST_TB: state_d = med_pkg::ST_UA;
					med_pkg::ST_UA: state_d = med_pkg::ST_UB;
					med_pkg::ST_UB: state_d = med_pkg::ST_UPD;
					default:        state_d = med_pkg::ST_IDLE;
				endcase
			end
		end
	end

	assign busy = (state_q != med_pkg::ST_IDLE);

`ifndef SYNTHESIS
	a_start_takes: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted pixel did not start");
	a_done_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == med_pkg::ST_DONE_ESC || state_q == med_pkg::ST_DONE_FREE)
		|=> !busy)
		else $error("sequencer did not return to idle after result");
	a_one_launch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.go |=> !cmd.go)
		else $error("multiplier launched twice in a row");
	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		stat.mul_done |-> issued_q)
		else $error("multiplier finished without a pending launch");
`endif
endmodule

[hw/rtl/mandelbrot_escape_distance.sv]
// mandelbrot_escape_distance: top level of the escape-time / distance pixel engine.
// Depends on med_pkg, med_ctrl, med_datapath (which holds med_mul).
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------------
//  pixel   | in        | start, busy             | px, py
//  result  | out       | done (one-cycle strobe) | iteration_count, last_z_*, dist_*
//  config  | in        | cfg_valid, cfg_ready    | cfg_index, cfg_data
//
// Every product goes through one shared 32x32 multiplier; the sequencer holds each
// product state through its launch, the multiplier run and the hand-back. Setup of c
// forms the c_re and c_im products, then loads z and d; each counted step forms z_re^2,
// z_im^2 and z_re*z_im, plus the t and u derivative products with the derivative on. An
// escaping pixel ends after its squares and magnitude check; a limit run at the loop test.
// Reset clears the sequencer and loads the register defaults; no clearing pass.
// busy stays high from acceptance through the cycle before the done strobe.
// The result receiver cannot stall; done marks each result for exactly one cycle.
// cfg_ready is always high; write config only while busy is low.
module mandelbrot_escape_distance #(
	parameter int unsigned ITER_BITS = med_pkg::ITER_BITS_DEF,
	parameter int unsigned PIXEL_COORD_BITS = med_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [PIXEL_COORD_BITS-1:0]       px,
	input  logic [PIXEL_COORD_BITS-1:0]       py,
	output logic                              done,
	output logic [ITER_BITS-1:0]              iteration_count,
	output logic signed [63:0]                last_z_re,
	output logic signed [63:0]                last_z_im,
	output logic signed [63:0]                dist_re,
	output logic signed [63:0]                dist_im,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [med_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [63:0]                       cfg_data
);
	med_pkg::cmd_t    cmd;
	med_pkg::status_t stat;

	// config writes are always taken and registered directly into the datapath
	assign cfg_ready = 1'b1;

	med_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .stat(stat)
	);

	med_datapath #(
		.ITER_BITS(ITER_BITS), .PIXEL_COORD_BITS(PIXEL_COORD_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.cfg_valid(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.px(px), .py(py), .done(done), .iteration_count(iteration_count),
		.last_z_re(last_z_re), .last_z_im(last_z_im),
		.dist_re(dist_re), .dist_im(dist_im)
	);
endmodule
